/* rtl/sna_pkg.sv */
`timescale 1ns / 1ps
package sna_pkg;

    localparam int NAME_SPACE_DEF = 1024;
    localparam int WORD_BITS      = 32;
    localparam int NAME_W         = 10;
    localparam int FIRST_W        = 10;
    localparam int END_W          = 11;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_ADDR_W     = 3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_FIRST = 1'b0;
    localparam logic REG_END   = 1'b1;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_SCAN
    } t_state;

    typedef struct packed {
        logic any_held;
        logic nf_found;
        logic held_above;
    } t_sum_flags;

    function automatic logic [4:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = 5'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [WORD_BITS-1:0] pad_mask(input logic last, input int last_bits);
        logic [WORD_BITS-1:0] m;
        m = '0;
        if (last && last_bits < WORD_BITS) begin
            m = ~((WORD_BITS'(1) << last_bits) - WORD_BITS'(1));
        end
        return m;
    endfunction

endpackage

/* rtl/sna_ram.sv */
`timescale 1ns / 1ps
module sna_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sna_summary.sv */
`timescale 1ns / 1ps
module sna_summary #(
    parameter int NAME_SPACE = sna_pkg::NAME_SPACE_DEF,
    localparam int WORDS     = (NAME_SPACE + sna_pkg::WORD_BITS - 1) / sna_pkg::WORD_BITS,
    localparam int WAW       = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_we,
    input  logic [WAW-1:0]            i_waddr,
    input  logic [sna_pkg::WORD_BITS-1:0] i_wdata,
    input  logic [WAW-1:0]            i_from,
    output logic [WAW-1:0]            o_low_word,
    output logic [WAW-1:0]            o_nf_word,
    output sna_pkg::t_sum_flags       o_flags
);

    localparam int LAST_BITS = NAME_SPACE - sna_pkg::WORD_BITS * (WORDS - 1);

    logic [WORDS-1:0] r_nonempty;
    logic [WORDS-1:0] r_full;
    logic [sna_pkg::WORD_BITS-1:0] pad;

    assign pad = sna_pkg::pad_mask(i_waddr == WAW'(WORDS - 1), LAST_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nonempty <= '0;
            r_full     <= '0;
        end else if (i_we) begin
            r_nonempty[i_waddr] <= (i_wdata != '0);
            r_full[i_waddr]     <= ((i_wdata | pad) == '1);
        end
    end

    always_comb begin
        o_low_word = '0;
        o_nf_word  = '0;
        o_flags    = '0;
        for (int i = WORDS - 1; i >= 0; i--) begin
            if (r_nonempty[i]) begin
                o_low_word       = WAW'(i);
                o_flags.any_held = 1'b1;
            end
            if (!r_full[i] && WAW'(i) > i_from) begin
                o_nf_word        = WAW'(i);
                o_flags.nf_found = 1'b1;
            end
            if (r_nonempty[i] && WAW'(i) > i_from) begin
                o_flags.held_above = 1'b1;
            end
        end
    end

endmodule

/* rtl/sna_ctrl.sv */
`timescale 1ns / 1ps
module sna_ctrl #(
    parameter int NAME_SPACE = sna_pkg::NAME_SPACE_DEF,
    localparam int WB        = sna_pkg::WORD_BITS,
    localparam int WORDS     = (NAME_SPACE + WB - 1) / WB,
    localparam int WAW       = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_cmd,
    input  logic [sna_pkg::NAME_W-1:0]    i_free_name,
    input  logic [sna_pkg::FIRST_W-1:0]   i_first,
    input  logic [sna_pkg::END_W-1:0]     i_end,
    output logic                          o_valid,
    output logic [sna_pkg::NAME_W-1:0]    o_given,
    output logic                          o_we,
    output logic [WAW-1:0]                o_waddr,
    output logic [sna_pkg::WORD_BITS-1:0] o_wdata,
    output logic [WAW-1:0]                o_raddr,
    input  logic [sna_pkg::WORD_BITS-1:0] i_rdata,
    output logic [WAW-1:0]                o_from,
    input  logic [WAW-1:0]                i_low_word,
    input  logic [WAW-1:0]                i_nf_word,
    input  sna_pkg::t_sum_flags           i_flags
);

    localparam int LAST_BITS = NAME_SPACE - WB * (WORDS - 1);
    localparam int NW        = $clog2(NAME_SPACE);
    localparam int VW        = ((NW > sna_pkg::END_W) ? NW : sna_pkg::END_W) + 1;

    sna_pkg::t_state r_state, n_state;
    logic                       r_cmd, n_cmd;
    logic [VW-1:0]              r_name, n_name;
    logic [WAW-1:0]             r_word, n_word;
    logic [WAW-1:0]             r_clr, n_clr;
    logic                       r_valid, n_valid;
    logic [sna_pkg::NAME_W-1:0] r_given, n_given;

    logic [VW-1:0] first_v, end_raw, end_v, base, low, nm, n_cand;
    logic [4:0]    lb, fb;
    logic [WB-1:0] pad, word_m, low_mask, above_bits;
    logic          ok;

    always_comb begin
        first_v  = VW'((i_first == '0) ? sna_pkg::FIRST_W'(1) : i_first);
        end_raw  = VW'(i_end);
        end_v    = (end_raw > VW'(NAME_SPACE)) ? VW'(NAME_SPACE) : end_raw;
        pad      = sna_pkg::pad_mask(r_word == WAW'(WORDS - 1), LAST_BITS);
        base     = VW'(r_word) << 5;
        lb       = sna_pkg::lowest_set(i_rdata);
        low      = base | VW'(lb);
        nm       = low - VW'(1);
        low_mask = WB'((64'd2 << lb) - 64'd1);
        word_m   = i_rdata | pad;
        if (r_state == sna_pkg::S_LOOK) begin
            word_m = word_m | low_mask;
        end
        fb         = sna_pkg::lowest_set(~word_m);
        n_cand     = base | VW'(fb);
        above_bits = i_rdata & ~WB'((64'd2 << fb) - 64'd1);
        ok         = (above_bits != '0) || i_flags.held_above || (n_cand < end_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sna_pkg::S_CLEAR;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_name  <= n_name;
        r_word  <= n_word;
        r_given <= n_given;
    end

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_name  = r_name;
        n_word  = r_word;
        n_clr   = r_clr;
        n_valid = 1'b0;
        n_given = r_given;
        o_we    = 1'b0;
        o_waddr = r_word;
        o_wdata = '0;
        o_raddr = r_word;
        unique case (r_state)
            sna_pkg::S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_clr;
                n_clr   = r_clr + WAW'(1);
                if (r_clr == WAW'(WORDS - 1)) begin
                    n_state = sna_pkg::S_IDLE;
                end
            end
            sna_pkg::S_IDLE: begin
                o_raddr = (i_cmd == sna_pkg::CMD_FREE) ? WAW'(VW'(i_free_name) >> 5)
                                                       : i_low_word;
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_name  = VW'(i_free_name);
                    n_word  = o_raddr;
                    n_state = sna_pkg::S_LOOK;
                end
            end
            sna_pkg::S_LOOK: begin
                n_given = '0;
                n_state = sna_pkg::S_IDLE;
                n_valid = 1'b1;
                if (r_cmd == sna_pkg::CMD_FREE) begin
                    if (r_name < VW'(NAME_SPACE)) begin
                        o_we    = 1'b1;
                        o_wdata = i_rdata & ~(WB'(1) << r_name[4:0]);
                    end
                end else if (!i_flags.any_held) begin
                    if (first_v < end_v) begin
                        o_we    = 1'b1;
                        o_waddr = WAW'(first_v >> 5);
                        o_wdata = WB'(1) << first_v[4:0];
                        n_given = first_v[sna_pkg::NAME_W-1:0];
                    end
                end else if (low > first_v) begin
                    o_we    = 1'b1;
                    o_waddr = WAW'(nm >> 5);
                    o_wdata = ((o_waddr == r_word) ? i_rdata : '0) | (WB'(1) << nm[4:0]);
                    n_given = nm[sna_pkg::NAME_W-1:0];
                end else if (word_m != '1) begin
                    if (ok) begin
                        o_we    = 1'b1;
                        o_wdata = i_rdata | (WB'(1) << fb);
                        n_given = n_cand[sna_pkg::NAME_W-1:0];
                    end
                end else if (i_flags.nf_found) begin
                    o_raddr = i_nf_word;
                    n_word  = i_nf_word;
                    n_valid = 1'b0;
                    n_state = sna_pkg::S_SCAN;
                end
            end
            sna_pkg::S_SCAN: begin
                n_given = '0;
                n_state = sna_pkg::S_IDLE;
                n_valid = 1'b1;
                if (ok) begin
                    o_we    = 1'b1;
                    o_wdata = i_rdata | (WB'(1) << fb);
                    n_given = n_cand[sna_pkg::NAME_W-1:0];
                end
            end
            default: begin
                n_state = sna_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != sna_pkg::S_IDLE);
    assign o_valid = r_valid;
    assign o_given = r_given;
    assign o_from  = r_word;

    a_strobe_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> $past(r_state == sna_pkg::S_LOOK || r_state == sna_pkg::S_SCAN))
        else $error("result strobe without a finished lookup");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> (r_state != sna_pkg::S_IDLE))
        else $error("bitmap write while idle");

    a_free_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_cmd == sna_pkg::CMD_FREE) |-> (r_given == '0))
        else $error("free word returned a name");

    a_name_is_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_given != '0) |-> $past(o_we))
        else $error("name handed out without a bitmap update");

endmodule

/* rtl/sparse_name_allocator.sv */
`timescale 1ns / 1ps
// Channel  Direction  Ports                                   Handshake
// command  in         i_cmd, i_free_name                      start high, busy low
// result   out        o_given_name                            o_valid for one cycle
// config   in/out     psel, penable, pwrite, paddr, pwdata,   write on access cycle
//                     prdata, pready
//
// After the accepting edge a free passes through the look state only; an allocation also
// passes through the scan state when the first free name lies past the word of the lowest
// held name and a second bitmap read is needed. The result strobe is high in the cycle
// after the last busy cycle, and the next word can be accepted at the end of that same cycle.
// The bitmap memory has a registered read port.
// After reset a clearing pass writes every bitmap word, one per cycle, with busy held high.
// The receiver cannot stall; each result word is shown for exactly one cycle.
module sparse_name_allocator #(
    parameter int NAME_SPACE = sna_pkg::NAME_SPACE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_cmd,
    input  logic [sna_pkg::NAME_W-1:0]        i_free_name,
    output logic                              o_valid,
    output logic [sna_pkg::NAME_W-1:0]        o_given_name,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sna_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [sna_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [sna_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int WORDS = (NAME_SPACE + sna_pkg::WORD_BITS - 1) / sna_pkg::WORD_BITS;
    localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [sna_pkg::FIRST_W-1:0] r_first;
    logic [sna_pkg::END_W-1:0]   r_end;
    logic                        reg_idx;

    logic                          ram_we;
    logic [WAW-1:0]                ram_waddr, ram_raddr, from_word, low_word, nf_word;
    logic [sna_pkg::WORD_BITS-1:0] ram_wdata, ram_rdata;
    sna_pkg::t_sum_flags           flags;

    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= sna_pkg::FIRST_W'(1);
            r_end   <= sna_pkg::END_W'(1024);
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                sna_pkg::REG_FIRST: r_first <= pwdata[sna_pkg::FIRST_W-1:0];
                sna_pkg::REG_END:   r_end   <= pwdata[sna_pkg::END_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            sna_pkg::REG_FIRST: prdata = sna_pkg::CFG_DATA_W'(r_first);
            sna_pkg::REG_END:   prdata = sna_pkg::CFG_DATA_W'(r_end);
            default:            prdata = '0;
        endcase
    end

    sna_ram #(
        .WIDTH(sna_pkg::WORD_BITS),
        .DEPTH(WORDS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    sna_summary #(
        .NAME_SPACE(NAME_SPACE)
    ) u_summary (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_from    (from_word),
        .o_low_word(low_word),
        .o_nf_word (nf_word),
        .o_flags   (flags)
    );

    sna_ctrl #(
        .NAME_SPACE(NAME_SPACE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_cmd      (i_cmd),
        .i_free_name(i_free_name),
        .i_first    (r_first),
        .i_end      (r_end),
        .o_valid    (o_valid),
        .o_given    (o_given_name),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata),
        .o_raddr    (ram_raddr),
        .i_rdata    (ram_rdata),
        .o_from     (from_word),
        .i_low_word (low_word),
        .i_nf_word  (nf_word),
        .i_flags    (flags)
    );

endmodule
